// File: design/ata_pkg.sv
package ata_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH       = 8;
  localparam int DWORDS_PER_SECTOR = 128;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic [2:0] KIND_PORT_WRITE = 3'd0;
  localparam logic [2:0] KIND_DATA_OUT   = 3'd1;
  localparam logic [2:0] KIND_DATA_IN    = 3'd2;
  localparam logic [2:0] KIND_COMPLETE   = 3'd3;
  localparam logic [2:0] KIND_REJECT     = 3'd4;

  // Status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_RANGE     = 3'd1;
  localparam logic [2:0] STS_ABSENT    = 3'd2;
  localparam logic [2:0] STS_FULL      = 3'd3;
  localparam logic [2:0] STS_DEV_ERROR = 3'd4;

  // Input modes
  localparam logic MODE_SUBMIT = 1'b0;
  localparam logic MODE_IRQ    = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SECTORS_PER_BLOCK = 2'd0;
  localparam logic [1:0] REG_BLOCK_LIMIT       = 2'd1;
  localparam logic [1:0] REG_DISK1_PRESENT     = 2'd2;

  // ATA ports
  localparam logic [9:0] PORT_DATA    = 10'h1f0;
  localparam logic [9:0] PORT_COUNT   = 10'h1f2;
  localparam logic [9:0] PORT_LBA0    = 10'h1f3;
  localparam logic [9:0] PORT_LBA1    = 10'h1f4;
  localparam logic [9:0] PORT_LBA2    = 10'h1f5;
  localparam logic [9:0] PORT_DRIVE   = 10'h1f6;
  localparam logic [9:0] PORT_COMMAND = 10'h1f7;
  localparam logic [9:0] PORT_CONTROL = 10'h3f6;

  // Commands and status bits
  localparam logic [7:0] CMD_READ        = 8'h20;
  localparam logic [7:0] CMD_WRITE       = 8'h30;
  localparam logic [7:0] CMD_READ_MULTI  = 8'hc4;
  localparam logic [7:0] CMD_WRITE_MULTI = 8'hc5;
  localparam logic [7:0] DRIVE_BASE      = 8'he0;
  localparam logic [3:0] LBA_TOP_MASK    = 4'h0f;
  localparam logic [7:0] ST_DF           = 8'h20;
  localparam logic [7:0] ST_ERR          = 8'h01;

  // Port write sequence steps
  localparam logic [2:0] STEP_CONTROL = 3'd0;
  localparam logic [2:0] STEP_COUNT   = 3'd1;
  localparam logic [2:0] STEP_LBA0    = 3'd2;
  localparam logic [2:0] STEP_LBA1    = 3'd3;
  localparam logic [2:0] STEP_LBA2    = 3'd4;
  localparam logic [2:0] STEP_DRIVE   = 3'd5;
  localparam logic [2:0] STEP_COMMAND = 3'd6;

  // One queued request
  typedef struct packed {
    logic [27:0] block;
    logic        drive;
    logic        write;
    logic [7:0]  tag;
  } req_t;

  localparam int REQ_W = $bits(req_t);

  function automatic logic [9:0] port_of_step(input logic [2:0] step);
    logic [9:0] p;
    case (step)
      STEP_CONTROL: p = PORT_CONTROL;
      STEP_COUNT:   p = PORT_COUNT;
      STEP_LBA0:    p = PORT_LBA0;
      STEP_LBA1:    p = PORT_LBA1;
      STEP_LBA2:    p = PORT_LBA2;
      STEP_DRIVE:   p = PORT_DRIVE;
      STEP_COMMAND: p = PORT_COMMAND;
      default:      p = PORT_CONTROL;
    endcase
    return p;
  endfunction

endpackage

// File: design/ata_in_if.sv
interface ata_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [27:0] block_number;
  logic        drive_select;
  logic        write_request;
  logic [7:0]  request_tag;
  logic [7:0]  drive_status;

  modport source(output valid, mode, block_number, drive_select, write_request,
                 request_tag, drive_status, input ready);
  modport sink(input valid, mode, block_number, drive_select, write_request,
               request_tag, drive_status, output ready);
endinterface

// File: design/ata_out_if.sv
interface ata_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [9:0] port_address;
  logic [7:0] port_value;
  logic [9:0] dword_count;
  logic [7:0] done_tag;
  logic [2:0] status_code;
  logic       last_of_run;

  modport source(output valid, result_kind, port_address, port_value, dword_count,
                 done_tag, status_code, last_of_run, input ready);
  modport sink(input valid, result_kind, port_address, port_value, dword_count,
               done_tag, status_code, last_of_run, output ready);
endinterface

// File: design/ata_cfg_if.sv
interface ata_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [27:0] data;

  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

// File: design/ata_ram.sv
module ata_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ata_pio_request_sequencer.sv
// ATA PIO LBA28 request sequencer. Submit beats queue a disk request in an
// on-chip FIFO memory; interrupt beats retire the request at the head. Every
// beat on req produces zero to ten result beats on rsp, at most one per cycle
// while rsp is ready, the last one flagged by last_of_run. A submit that
// queues behind others produces no result; a reject produces one; a submit
// that starts a request computes its sector address, then emits seven port
// writes, one more for a write. An interrupt reads the head from queue
// memory, emits its retire results, and when another request is waiting,
// reads it and computes its sector address before its start results. The
// queue memory read is registered and all results pass through the single
// result register. Configuration writes on cfg are always taken and must be
// made while no beat is in progress. No clearing pass is needed after reset.
module ata_pio_request_sequencer (
  input  logic       clk,
  input  logic       rst,
  ata_in_if.sink     req,
  ata_out_if.source  rsp,
  ata_cfg_if.sink    cfg
);
  import ata_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REJ    = 4'd1;
  localparam logic [3:0] S_POP_RD = 4'd2;
  localparam logic [3:0] S_XIN    = 4'd3;
  localparam logic [3:0] S_DONE   = 4'd4;
  localparam logic [3:0] S_NXT_RD = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_PW     = 4'd7;
  localparam logic [3:0] S_XOUT   = 4'd8;

  // Configuration
  logic [2:0]  sectors_per_block;
  logic [27:0] block_limit;
  logic        disk1_present;

  // Queue control
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;

  // Sequencer
  logic [3:0]  state;
  logic [2:0]  step;
  req_t        cur;
  logic [27:0] sector;
  logic [7:0]  status;
  logic [2:0]  rej_code;
  logic        err;

  // Result register
  logic       o_valid;
  logic [2:0] o_kind;
  logic [9:0] o_addr;
  logic [7:0] o_val;
  logic [9:0] o_cnt;
  logic [7:0] o_tag;
  logic [2:0] o_code;
  logic       o_last;

  // Queue memory
  logic             ram_we;
  logic             ram_re;
  req_t             ram_wdata;
  logic [REQ_W-1:0] ram_rdata;
  req_t             head_req;

  ata_ram #(.WIDTH(REQ_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  assign head_req = req_t'(ram_rdata);

  logic        in_fire;
  logic        out_free;
  logic        emit;
  logic        fire;
  logic [2:0]  chk_code;
  logic [9:0]  dwords;
  logic [7:0]  cmd;
  logic [30:0] product;
  logic        rd_err;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_inc;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign out_free  = !o_valid || rsp.ready;

  assign dwords  = 10'(sectors_per_block * DWORDS_PER_SECTOR);
  assign product = 31'(cur.block) * 31'(sectors_per_block);
  assign rd_err  = !head_req.write && ((status & (ST_DF | ST_ERR)) != 8'h00);
  assign head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  // Check a submit: range, then drive, then room
  always_comb begin
    if (req.block_number >= block_limit) begin
      chk_code = STS_RANGE;
    end else if (req.drive_select && !disk1_present) begin
      chk_code = STS_ABSENT;
    end else if (count >= CNT_W'(QUEUE_DEPTH)) begin
      chk_code = STS_FULL;
    end else begin
      chk_code = STS_OK;
    end
  end

  always_comb begin
    if (sectors_per_block == 3'd1) begin
      cmd = cur.write ? CMD_WRITE : CMD_READ;
    end else begin
      cmd = cur.write ? CMD_WRITE_MULTI : CMD_READ_MULTI;
    end
  end

  // Queue memory access
  always_comb begin
    ram_wdata.block = req.block_number;
    ram_wdata.drive = req.drive_select;
    ram_wdata.write = req.write_request;
    ram_wdata.tag   = req.request_tag;
    ram_we = in_fire && (req.mode == MODE_SUBMIT) && (chk_code == STS_OK);
    ram_re = (in_fire && (req.mode == MODE_IRQ) && (count != '0)) ||
             (state == S_DONE && fire && (count != '0));
  end

  // Build the next result beat
  logic [2:0] e_kind;
  logic [9:0] e_addr;
  logic [7:0] e_val;
  logic [9:0] e_cnt;
  logic [7:0] e_tag;
  logic [2:0] e_code;
  logic       e_last;

  always_comb begin
    emit   = 1'b0;
    e_kind = KIND_PORT_WRITE;
    e_addr = '0;
    e_val  = '0;
    e_cnt  = '0;
    e_tag  = '0;
    e_code = STS_OK;
    e_last = 1'b0;
    case (state)
      S_REJ: begin
        emit   = 1'b1;
        e_kind = KIND_REJECT;
        e_tag  = cur.tag;
        e_code = rej_code;
        e_last = 1'b1;
      end
      S_XIN: begin
        emit   = 1'b1;
        e_kind = KIND_DATA_IN;
        e_addr = PORT_DATA;
        e_cnt  = dwords;
      end
      S_DONE: begin
        emit   = 1'b1;
        e_kind = KIND_COMPLETE;
        e_tag  = cur.tag;
        e_code = err ? STS_DEV_ERROR : STS_OK;
        e_last = (count == '0);
      end
      S_PW: begin
        emit   = 1'b1;
        e_kind = KIND_PORT_WRITE;
        e_addr = port_of_step(step);
        e_last = (step == STEP_COMMAND) && !cur.write;
        case (step)
          STEP_CONTROL: e_val = 8'h00;
          STEP_COUNT:   e_val = {5'b0, sectors_per_block};
          STEP_LBA0:    e_val = sector[7:0];
          STEP_LBA1:    e_val = sector[15:8];
          STEP_LBA2:    e_val = sector[23:16];
          STEP_DRIVE:   e_val = DRIVE_BASE | {3'b0, cur.drive, 4'h0} |
                                {4'h0, sector[27:24] & LBA_TOP_MASK};
          STEP_COMMAND: e_val = cmd;
          default:      e_val = 8'h00;
        endcase
      end
      S_XOUT: begin
        emit   = 1'b1;
        e_kind = KIND_DATA_OUT;
        e_addr = PORT_DATA;
        e_cnt  = dwords;
        e_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  assign fire = emit && out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_block <= 3'd1;
      block_limit       <= 28'd1000;
      disk1_present     <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.addr)
        REG_SECTORS_PER_BLOCK: sectors_per_block <= cfg.data[2:0];
        REG_BLOCK_LIMIT:       block_limit       <= cfg.data;
        REG_DISK1_PRESENT:     disk1_present     <= cfg.data[0];
        default:               ;
      endcase
    end
  end

  // Sequencer and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      step  <= STEP_CONTROL;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (req.mode == MODE_SUBMIT) begin
              cur.block <= req.block_number;
              cur.drive <= req.drive_select;
              cur.write <= req.write_request;
              cur.tag   <= req.request_tag;
              rej_code  <= chk_code;
              if (chk_code != STS_OK) begin
                state <= S_REJ;
              end else begin
                tail  <= tail_inc;
                count <= count + 1'b1;
                if (count == '0) begin
                  state <= S_MUL;
                end
              end
            end else begin
              status <= req.drive_status;
              if (count != '0) begin
                state <= S_POP_RD;
              end
            end
          end
        end
        S_REJ: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        S_POP_RD: begin
          // Retire the head entry just read
          cur   <= head_req;
          err   <= rd_err;
          head  <= head_inc;
          count <= count - 1'b1;
          state <= (!head_req.write && !rd_err) ? S_XIN : S_DONE;
        end
        S_XIN: begin
          if (fire) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (fire) begin
            state <= (count != '0) ? S_NXT_RD : S_IDLE;
          end
        end
        S_NXT_RD: begin
          cur   <= head_req;
          state <= S_MUL;
        end
        S_MUL: begin
          sector <= product[27:0];
          step   <= STEP_CONTROL;
          state  <= S_PW;
        end
        S_PW: begin
          if (fire) begin
            if (step == STEP_COMMAND) begin
              state <= cur.write ? S_XOUT : S_IDLE;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        S_XOUT: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register: load on fire, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fire) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_kind <= e_kind;
      o_addr <= e_addr;
      o_val  <= e_val;
      o_cnt  <= e_cnt;
      o_tag  <= e_tag;
      o_code <= e_code;
      o_last <= e_last;
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.result_kind  = o_kind;
  assign rsp.port_address = o_addr;
  assign rsp.port_value   = o_val;
  assign rsp.dword_count  = o_cnt;
  assign rsp.done_tag     = o_tag;
  assign rsp.status_code  = o_code;
  assign rsp.last_of_run  = o_last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_W'(QUEUE_DEPTH)) |-> (head == tail))
    else $error("queue pointers disagree with count");

  a_reject_code: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.result_kind == KIND_REJECT) |-> (rsp.status_code != STS_OK))
    else $error("reject beat without a reject code");

  a_start_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (count != '0))
    else $error("request started with empty queue");

endmodule
